FILE: hw/rtl/tlc_pkg.sv
// Shared constants for the traffic light controller: command codes,
// register indexes, register reset values and field widths.
// No dependencies.
package tlc_pkg;

    localparam int CmdW    = 2;
    localparam int CountW  = 8;
    localparam int TotalW  = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 8;
    localparam int GreenW  = 7;

    // Command codes carried by the cmd field
    localparam logic [CmdW-1:0] CMD_TICK   = 2'd0;
    localparam logic [CmdW-1:0] CMD_ARRIVE = 2'd1;
    localparam logic [CmdW-1:0] CMD_TOGGLE = 2'd2;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_GREEN_TICKS    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_YELLOW_TICKS   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RED_TICKS      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BUSY_EXTENSION = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BUSY_THRESHOLD = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PASS_PER_TICK  = 3'd5;

    // Register reset values
    localparam logic [GreenW-1:0] GREEN_TICKS_RST    = 7'd5;
    localparam logic [CountW-1:0] YELLOW_TICKS_RST   = 8'd2;
    localparam logic [CountW-1:0] RED_TICKS_RST      = 8'd4;
    localparam logic [GreenW-1:0] BUSY_EXTENSION_RST = 7'd2;
    localparam logic [CountW-1:0] BUSY_THRESHOLD_RST = 8'd6;
    localparam logic [CountW-1:0] PASS_PER_TICK_RST  = 8'd2;

endpackage

FILE: hw/rtl/traffic_light_controller_top.sv
// Traffic light controller: one command word in, one status word out per command.
// One input register stage; the state registers drive the result ports directly.
// Depends on tlc_pkg.
//
// One command word is taken per clock while in_stall is low; it passes the input
// register, and its status word is held in the state registers. The whole update
// (queue drain, busy compare, phase countdown) is one pass of logic between them.
// While a status word waits under out_stall the state holds, and one more command
// can sit in the input register. Configuration writes are always ready and apply
// to the next command that uses them; write them only while the block is idle.
module traffic_light_controller_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tlc_pkg::CmdW-1:0]    cmd,
    input  logic [tlc_pkg::CountW-1:0]  car_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  light_color,
    output logic [tlc_pkg::CountW-1:0]  ticks_remaining,
    output logic [tlc_pkg::CountW-1:0]  queue_count,
    output logic [tlc_pkg::TotalW-1:0]  passed_total,
    output logic [tlc_pkg::TotalW-1:0]  tick_total,
    output logic                        night_mode,
    output logic                        busy_flag,
    output logic                        blink_lamp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tlc_pkg::CfgW-1:0]    cfg_data
);
    import tlc_pkg::*;

    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_YELLOW = 2'd1,
        COLOR_RED    = 2'd2
    } color_t;

    // configuration registers
    logic [GreenW-1:0] green_ticks_reg;
    logic [CountW-1:0] yellow_ticks_reg;
    logic [CountW-1:0] red_ticks_reg;
    logic [GreenW-1:0] busy_extension_reg;
    logic [CountW-1:0] busy_threshold_reg;
    logic [CountW-1:0] pass_per_tick_reg;

    // input stage
    logic              in_full_reg;
    logic [CmdW-1:0]   cmd_reg;
    logic [CountW-1:0] car_count_reg;

    // controller state, also the result word
    color_t            color_reg, color_next;
    logic [CountW-1:0] phase_reg, phase_next;
    logic [CountW-1:0] waiting_reg, waiting_next;
    logic [TotalW-1:0] passed_reg, passed_next;
    logic [TotalW-1:0] elapsed_reg, elapsed_next;
    logic              night_reg, night_next;
    logic              busy_reg, busy_next;
    logic              blink_reg, blink_next;
    logic              out_valid_reg;

    logic              advance;
    logic [CountW-1:0] go;
    logic [CountW-1:0] drained;
    logic [CountW:0]   arrive_sum;
    logic [CountW-1:0] arrived;
    logic [CountW-1:0] green_len;

    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign light_color     = color_reg;
    assign ticks_remaining = phase_reg;
    assign queue_count     = waiting_reg;
    assign passed_total    = passed_reg;
    assign tick_total      = elapsed_reg;
    assign night_mode      = night_reg;
    assign busy_flag       = busy_reg;
    assign blink_lamp      = blink_reg;

    always_comb
    begin
        color_next   = color_reg;
        phase_next   = phase_reg;
        waiting_next = waiting_reg;
        passed_next  = passed_reg;
        elapsed_next = elapsed_reg;
        night_next   = night_reg;
        busy_next    = busy_reg;
        blink_next   = blink_reg;

        go         = (waiting_reg < pass_per_tick_reg) ? waiting_reg : pass_per_tick_reg;
        drained    = (color_reg == COLOR_GREEN) ? (waiting_reg - go) : waiting_reg;
        arrive_sum = {1'b0, waiting_reg} + {1'b0, car_count_reg};
        arrived    = arrive_sum[CountW] ? {CountW{1'b1}} : arrive_sum[CountW-1:0];
        green_len  = {1'b0, green_ticks_reg}
                   + ((drained > busy_threshold_reg) ? {1'b0, busy_extension_reg}
                                                     : {CountW{1'b0}});

        case (cmd_reg)
            CMD_TICK:
            begin
                elapsed_next = elapsed_reg + TotalW'(1);
                if (night_reg)
                begin
                    blink_next = !blink_reg;
                end
                else
                begin
                    if (color_reg == COLOR_GREEN)
                    begin
                        passed_next = passed_reg + {{(TotalW-CountW){1'b0}}, go};
                    end
                    waiting_next = drained;
                    busy_next    = drained > busy_threshold_reg;
                    if (phase_reg <= 8'd1)
                    begin
                        case (color_reg)
                            COLOR_GREEN:
                            begin
                                color_next = COLOR_YELLOW;
                                phase_next = yellow_ticks_reg;
                            end
                            COLOR_YELLOW:
                            begin
                                color_next = COLOR_RED;
                                phase_next = red_ticks_reg;
                            end
                            default:
                            begin
                                // green length uses the busy flag just computed
                                color_next = COLOR_GREEN;
                                phase_next = green_len;
                            end
                        endcase
                    end
                    else
                    begin
                        phase_next = phase_reg - 8'd1;
                    end
                end
            end
            CMD_ARRIVE:
            begin
                if (car_count_reg != '0)
                begin
                    waiting_next = arrived;
                    if (arrived > busy_threshold_reg)
                    begin
                        busy_next = 1'b1;
                    end
                end
            end
            CMD_TOGGLE:
            begin
                night_next = !night_reg;
                blink_next = !night_reg;
                if (night_reg)
                begin
                    color_next = COLOR_RED;
                    phase_next = red_ticks_reg;
                end
            end
            default:
            begin
                // unused command: status word repeats the state
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_ticks_reg    <= GREEN_TICKS_RST;
            yellow_ticks_reg   <= YELLOW_TICKS_RST;
            red_ticks_reg      <= RED_TICKS_RST;
            busy_extension_reg <= BUSY_EXTENSION_RST;
            busy_threshold_reg <= BUSY_THRESHOLD_RST;
            pass_per_tick_reg  <= PASS_PER_TICK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GREEN_TICKS:    green_ticks_reg    <= cfg_data[GreenW-1:0];
                REG_YELLOW_TICKS:   yellow_ticks_reg   <= cfg_data;
                REG_RED_TICKS:      red_ticks_reg      <= cfg_data;
                REG_BUSY_EXTENSION: busy_extension_reg <= cfg_data[GreenW-1:0];
                REG_BUSY_THRESHOLD: busy_threshold_reg <= cfg_data;
                REG_PASS_PER_TICK:  pass_per_tick_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register: load when empty or when its word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg       <= cmd;
            car_count_reg <= car_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RED;
            phase_reg     <= RED_TICKS_RST;
            waiting_reg   <= '0;
            passed_reg    <= '0;
            elapsed_reg   <= '0;
            night_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            blink_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                color_reg   <= color_next;
                phase_reg   <= phase_next;
                waiting_reg <= waiting_next;
                passed_reg  <= passed_next;
                elapsed_reg <= elapsed_next;
                night_reg   <= night_next;
                busy_reg    <= busy_next;
                blink_reg   <= blink_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_advance_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed command produced no status word");

    a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(waiting_reg) && $stable(phase_reg)
                                      && $stable(elapsed_reg)))
        else $error("state moved under a stalled status word");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_TICK)
        |=> (elapsed_reg == $past(elapsed_reg) + TotalW'(1)))
        else $error("tick total did not step on a tick");

    a_enter_night: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_TOGGLE && !night_reg) |=> (night_reg && blink_reg))
        else $error("entering night mode did not light the blink lamp");

    a_leave_night_red: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CMD_TOGGLE && night_reg)
        |=> (color_reg == COLOR_RED && !blink_reg))
        else $error("leaving night mode did not force red");

endmodule
